@@ sv/grq_pkg.sv @@
// Shared constants, types and helpers for the graph reachability query core.
package grq_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VERTEX_W     = $clog2(MAX_VERTICES);
   localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
   localparam int KIND_W       = 2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_VERTICES);

   // Request kind codes
   localparam logic [KIND_W-1:0] KIND_ADD_EDGE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

   typedef logic [MAX_VERTICES-1:0] vset_type;
   typedef logic [VERTEX_W-1:0]     vertex_type;

   // Access to the adjacency store
   typedef struct packed {
      logic       rd_en;
      vertex_type rd_addr;
      logic       wr_en;
      vertex_type wr_addr;
      vset_type   wr_row;
      logic       clear;
   } store_req_type;

   // Control of the frontier sets
   typedef struct packed {
      logic       init;
      vertex_type seed;
      vertex_type target;
      logic       issue;
      logic       merge;
   } frontier_ctl_type;

   // Status of the frontier sets
   typedef struct packed {
      logic       has_cand;
      vertex_type cand;
      logic       end_hit;
   } frontier_stat_type;

   // One-hot set holding a single vertex
   function automatic vset_type vertex_bit(input vertex_type v);
      vset_type result;
      result = vset_type'(1) << v;
      return result;
   endfunction

endpackage

@@ sv/graph_reachability_query_core.sv @@
// Top level: request sequencer for edge updates, clears and path queries.
//
//  Channel   Ports                                     Handshake
//  request   req_kind, req_vertex_a, req_vertex_b      start && !busy
//  response  rsp_path_found                            rsp_strobe, one cycle
//  config    csr_wr_data                               csr_wr_en
//
// Add edge: two read-modify-writes of the adjacency memory (RD_A, WR_A, RD_B, WR_B).
// Clear: done by dropping all row valid bits. Unused kind: no action.
// Query: answered without a search when start equals end or a vertex is out of
// range; otherwise the accept cycle seeds the search, each expanded vertex issues
// a read of its row on the single read port, the search waits on a fetched row to
// merge when no candidate is left, and a final check gives the answer.
// Reset clears the graph at once; no sweep follows. The response cannot stall.
module graph_reachability_query_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [grq_pkg::KIND_W-1:0]  req_kind,
   input  logic [grq_pkg::VERTEX_W-1:0] req_vertex_a,
   input  logic [grq_pkg::VERTEX_W-1:0] req_vertex_b,
   output logic                    rsp_strobe,
   output logic                    rsp_path_found,
   input  logic                    csr_wr_en,
   input  logic [grq_pkg::COUNT_W-1:0] csr_wr_data
);
   import grq_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD_A = 6'b000010,
      ST_WR_A = 6'b000100,
      ST_RD_B = 6'b001000,
      ST_WR_B = 6'b010000,
      ST_RUN  = 6'b100000
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [COUNT_W-1:0]   vertex_count_ff;
   vertex_type           a_ff;
   vertex_type           a_in;
   vertex_type           b_ff;
   vertex_type           b_in;
   logic                 in_range_ff;
   logic                 in_range_in;
   logic                 pend_ff;
   logic                 pend_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_found_ff;
   logic                 rsp_found_in;
   vset_type             limit_mask;
   vset_type             rd_row;
   store_req_type        sreq;
   frontier_ctl_type     fctl;
   frontier_stat_type    fstat;

   // Hold the vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         vertex_count_ff <= csr_wr_data;
      end
   end

   // Mark vertices below the usable limit
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         limit_mask[i] = COUNT_W'(i) < vertex_count_ff;
      end
   end

   // Sequence requests
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      in_range_in  = in_range_ff;
      pend_in      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      sreq         = '0;
      fctl         = '0;
      fctl.seed    = a_ff;
      fctl.target  = b_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_ADD_EDGE: begin
                     a_in        = req_vertex_a;
                     b_in        = req_vertex_b;
                     in_range_in = limit_mask[req_vertex_a] & limit_mask[req_vertex_b];
                     state_in    = ST_RD_A;
                  end
                  KIND_QUERY: begin
                     if (!(limit_mask[req_vertex_a] & limit_mask[req_vertex_b])) begin
                        rsp_valid_in = 1'b1;
                        rsp_found_in = 1'b0;
                     end else if (req_vertex_a == req_vertex_b) begin
                        rsp_valid_in = 1'b1;
                        rsp_found_in = 1'b1;
                     end else begin
                        fctl.init   = 1'b1;
                        fctl.seed   = req_vertex_a;
                        fctl.target = req_vertex_b;
                        state_in    = ST_RUN;
                     end
                  end
                  KIND_CLEAR: begin
                     sreq.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD_A: begin
            sreq.rd_en   = 1'b1;
            sreq.rd_addr = a_ff;
            state_in     = ST_WR_A;
         end
         ST_WR_A: begin
            sreq.wr_en   = in_range_ff;
            sreq.wr_addr = a_ff;
            sreq.wr_row  = rd_row | vertex_bit(b_ff);
            state_in     = ST_RD_B;
         end
         ST_RD_B: begin
            sreq.rd_en   = 1'b1;
            sreq.rd_addr = b_ff;
            state_in     = ST_WR_B;
         end
         ST_WR_B: begin
            sreq.wr_en   = in_range_ff;
            sreq.wr_addr = b_ff;
            sreq.wr_row  = rd_row | vertex_bit(a_ff);
            state_in     = ST_IDLE;
         end
         ST_RUN: begin
            // merge the row fetched last cycle, fetch the next one
            fctl.merge = pend_ff;
            if (fstat.end_hit) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (fstat.has_cand) begin
               sreq.rd_en   = 1'b1;
               sreq.rd_addr = fstat.cand;
               fctl.issue   = 1'b1;
               pend_in      = 1'b1;
            end else if (!pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      in_range_ff  <= in_range_in;
      rsp_found_ff <= rsp_found_in;
   end

   grq_adj_store u_store (
      .clock  (clock),
      .reset  (reset),
      .req    (sreq),
      .rd_row (rd_row)
   );

   grq_frontier u_frontier (
      .clock      (clock),
      .reset      (reset),
      .ctl        (fctl),
      .limit_mask (limit_mask),
      .rd_row     (rd_row),
      .stat       (fstat)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_path_found = rsp_found_ff;

endmodule

@@ sv/grq_adj_store.sv @@
// Adjacency matrix memory with per-row valid bits so that a clear drops all rows at once.
module grq_adj_store (
   input  logic                 clock,
   input  logic                 reset,
   input  grq_pkg::store_req_type req,
   output grq_pkg::vset_type    rd_row
);
   import grq_pkg::*;

   vset_type adj_mem_ff [MAX_VERTICES];
   vset_type rd_data_ff;
   vset_type row_valid_ff;
   vset_type row_valid_in;
   logic     rd_valid_ff;
   logic     rd_valid_in;

   // Write and registered read of the row memory
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         adj_mem_ff[req.wr_addr] <= req.wr_row;
      end
      if (req.rd_en) begin
         rd_data_ff <= adj_mem_ff[req.rd_addr];
      end
   end

   // Track rows written since the last clear
   always_comb begin
      row_valid_in = row_valid_ff;
      rd_valid_in  = rd_valid_ff;
      if (req.rd_en) begin
         rd_valid_in = row_valid_ff[req.rd_addr];
      end
      if (req.clear) begin
         row_valid_in = '0;
      end else if (req.wr_en) begin
         row_valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   // Drop stale data of rows not written since clear
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ sv/grq_frontier.sv @@
// Reached and expanded vertex sets with next-vertex selection.
module grq_frontier (
   input  logic                     clock,
   input  logic                     reset,
   input  grq_pkg::frontier_ctl_type ctl,
   input  grq_pkg::vset_type        limit_mask,
   input  grq_pkg::vset_type        rd_row,
   output grq_pkg::frontier_stat_type stat
);
   import grq_pkg::*;

   vset_type   reached_ff;
   vset_type   reached_in;
   vset_type   expanded_ff;
   vset_type   expanded_in;
   vertex_type target_ff;
   vertex_type target_in;
   vset_type   open_set;

   // Pick the lowest reached vertex not yet expanded
   always_comb begin
      open_set      = reached_ff & ~expanded_ff & limit_mask;
      stat.has_cand = |open_set;
      stat.cand     = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (open_set[i]) begin
            stat.cand = VERTEX_W'(i);
         end
      end
      stat.end_hit = reached_ff[target_ff];
   end

   // Seed, mark expanded, merge fetched rows
   always_comb begin
      reached_in  = reached_ff;
      expanded_in = expanded_ff;
      target_in   = target_ff;
      if (ctl.init) begin
         reached_in  = vertex_bit(ctl.seed);
         expanded_in = '0;
         target_in   = ctl.target;
      end else begin
         if (ctl.merge) begin
            reached_in = reached_ff | (rd_row & limit_mask);
         end
         if (ctl.issue) begin
            expanded_in = expanded_ff | vertex_bit(stat.cand);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reached_ff  <= '0;
         expanded_ff <= '0;
         target_ff   <= '0;
      end else begin
         reached_ff  <= reached_in;
         expanded_ff <= expanded_in;
         target_ff   <= target_in;
      end
   end

endmodule

@@ sv/grq_checker.sv @@
// Port-level checker for the graph reachability query core, with its bind.
module grq_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [grq_pkg::KIND_W-1:0]  req_kind,
   input logic [grq_pkg::VERTEX_W-1:0] req_vertex_a,
   input logic [grq_pkg::VERTEX_W-1:0] req_vertex_b,
   input logic                    rsp_strobe
);
   import grq_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // A query with equal endpoints answers in the next cycle
   a_same_vertex_answers: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_QUERY && req_vertex_a == req_vertex_b |=> rsp_strobe)
      else $error("query with equal endpoints did not answer at once");

   // An edge update occupies the core after acceptance
   a_edge_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_ADD_EDGE |=> busy && !rsp_strobe)
      else $error("edge update did not hold the core busy");

   // Clear and unused kinds finish at once without a response
   a_no_rsp_kinds: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind != KIND_ADD_EDGE && req_kind != KIND_QUERY |=> !busy && !rsp_strobe)
      else $error("clear or unused kind gave a response or held the core");

   // A response comes only with the core free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while still busy");

endmodule

bind graph_reachability_query_core grq_checker u_grq_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_kind     (req_kind),
   .req_vertex_a (req_vertex_a),
   .req_vertex_b (req_vertex_b),
   .rsp_strobe   (rsp_strobe)
);
